/* design/rrgs_pkg.sv */
// ----------------------------------------------------------------------------
// rrgs_pkg
// types and constants shared by the rounded rectangle gradient shader
// ----------------------------------------------------------------------------
`default_nettype none

package rrgs_pkg;

    localparam int COORD_BITS = 16;
    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 9;
    localparam int D2_BITS    = 15;

    typedef enum logic [2:0] {
        CFG_RECT_LEFT     = 3'd0,
        CFG_RECT_TOP      = 3'd1,
        CFG_RECT_WIDTH    = 3'd2,
        CFG_RECT_HEIGHT   = 3'd3,
        CFG_CORNER_RADIUS = 3'd4,
        CFG_TOP_COLOR     = 3'd5,
        CFG_BOTTOM_COLOR  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
    } t_pixel;

    typedef struct packed {
        logic                         write_enable;
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic [31:0]                  pixel_color;
    } t_result;

    // item travelling through the iterative divide and square root stages
    typedef struct packed {
        logic                         valid;
        logic                         in_rect;
        logic                         corner;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [D2_BITS-1:0]           d2;
        logic [23:0]                  drem;
        logic [DIV_STEPS-1:0]         dq;
        logic [26:0]                  srem;
        logic [SQRT_STEPS-1:0]        sq;
    } t_work;

endpackage

`default_nettype wire

/* design/rrgs_iter_stage.sv */
// ----------------------------------------------------------------------------
// rrgs_iter_stage
// one registered step of the row weight divider and the distance square root
// ----------------------------------------------------------------------------
`default_nettype none

module rrgs_iter_stage #(
    parameter int STAGE = 0
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire         [14:0] i_denom,
    input  rrgs_pkg::t_work    i_prev,
    output rrgs_pkg::t_work    o_work
);
    import rrgs_pkg::*;

    t_work       n_work;
    t_work       r_work;
    logic [15:0] nh;
    logic [1:0]  pair;
    logic [26:0] rem_sh;
    logic [26:0] trial;
    logic [23:0] dsub;

    always_comb begin
        n_work = i_prev;
        nh     = {1'b0, i_prev.d2};
        // restoring divide, one quotient bit per step
        if (STAGE < DIV_STEPS) begin
            dsub = 24'(i_denom) << (DIV_STEPS - 1 - STAGE);
            if (i_prev.drem >= dsub) begin
                n_work.drem = i_prev.drem - dsub;
                n_work.dq   = i_prev.dq | (DIV_STEPS'(1) << (DIV_STEPS - 1 - STAGE));
            end
        end else begin
            dsub = '0;
        end
        // digit recurrence square root, operand is d2 shifted up by 32
        if (STAGE < 8) begin
            pair = nh[(15 - 2*(STAGE % 8)) -: 2];
        end else begin
            pair = 2'b00;
        end
        rem_sh = {i_prev.srem[24:0], pair};
        trial  = {1'b0, i_prev.sq, 2'b01};
        if (rem_sh >= trial) begin
            n_work.srem = rem_sh - trial;
            n_work.sq   = {i_prev.sq[SQRT_STEPS-2:0], 1'b1};
        end else begin
            n_work.srem = rem_sh;
            n_work.sq   = {i_prev.sq[SQRT_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work.valid <= 1'b0;
        end else begin
            r_work.valid <= n_work.valid;
        end
        r_work.in_rect <= n_work.in_rect;
        r_work.corner  <= n_work.corner;
        r_work.x       <= n_work.x;
        r_work.y       <= n_work.y;
        r_work.d2      <= n_work.d2;
        r_work.drem    <= n_work.drem;
        r_work.dq      <= n_work.dq;
        r_work.srem    <= n_work.srem;
        r_work.sq      <= n_work.sq;
    end

    assign o_work = r_work;

endmodule

`default_nettype wire

/* design/rounded_rect_gradient_shader.sv */
// a pixel taken with start passes stages 0 to 2, the iterative stages, tail stages 1 to 3 and the output register
// throughput: one pixel per cycle, busy is always low
// the depth is set by the square root, one result bit per pipeline stage
// reset: synchronous active low, clears all valid bits and the configuration registers
// the receiver cannot stall, results appear for one cycle with the strobe
// ----------------------------------------------------------------------------
// rounded_rect_gradient_shader
// vertical gradient fill of a rounded rectangle with antialiased corners
// ----------------------------------------------------------------------------
`default_nettype none

module rounded_rect_gradient_shader #(
    parameter int MAX_RADIUS = 127
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    output logic               o_busy,
    input  rrgs_pkg::t_pixel   i_pixel,
    output logic               o_strobe,
    output rrgs_pkg::t_result  o_result,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire         [2:0]  i_cfg_index,
    input  wire         [31:0] i_cfg_data
);
    import rrgs_pkg::*;

    // configuration registers
    logic signed [15:0] r_left;
    logic signed [15:0] r_top;
    logic [14:0]        r_width;
    logic [14:0]        r_height;
    logic [6:0]         r_radius;
    logic [31:0]        r_top_color;
    logic [31:0]        r_bot_color;

    logic [6:0]  rad;
    logic [14:0] denom;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_top       <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_radius    <= '0;
            r_top_color <= '0;
            r_bot_color <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RECT_LEFT:     r_left      <= i_cfg_data[15:0];
                CFG_RECT_TOP:      r_top       <= i_cfg_data[15:0];
                CFG_RECT_WIDTH:    r_width     <= i_cfg_data[14:0];
                CFG_RECT_HEIGHT:   r_height    <= i_cfg_data[14:0];
                CFG_CORNER_RADIUS: r_radius    <= i_cfg_data[6:0];
                CFG_TOP_COLOR:     r_top_color <= i_cfg_data;
                CFG_BOTTOM_COLOR:  r_bot_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // radius saturates, divisor is height minus one but never zero
    assign rad   = (r_radius > 7'(MAX_RADIUS)) ? 7'(MAX_RADIUS) : r_radius;
    assign denom = (r_height > 15'd1) ? (r_height - 15'd1) : 15'd1;

    // stage 0: coordinates relative to the rectangle origin
    logic               r_s0_valid;
    logic signed [15:0] r_s0_x;
    logic signed [15:0] r_s0_y;
    logic signed [16:0] r_s0_rx;
    logic signed [16:0] r_s0_ry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= i_start && !o_busy;
        end
        r_s0_x  <= i_pixel.pixel_x;
        r_s0_y  <= i_pixel.pixel_y;
        r_s0_rx <= 17'(i_pixel.pixel_x) - 17'(r_left);
        r_s0_ry <= 17'(i_pixel.pixel_y) - 17'(r_top);
    end

    // stage 1: inside test and corner square selection, first match wins
    logic signed [17:0] rx18, ry18, r18, w18, h18;
    logic signed [17:0] cx_l, cx_r, cy_t, cy_b;
    logic               left_sq, right_sq, top_sq, bot_sq;
    logic               n_inside, n_corner;
    logic [6:0]         n_cx, n_cy;

    always_comb begin
        rx18     = 18'(r_s0_rx);
        ry18     = 18'(r_s0_ry);
        r18      = 18'($signed({11'b0, rad}));
        w18      = 18'($signed({3'b0, r_width}));
        h18      = 18'($signed({3'b0, r_height}));
        n_inside = !r_s0_rx[16] && !r_s0_ry[16] && (rx18 < w18) && (ry18 < h18);
        left_sq  = rx18 < r18;
        right_sq = rx18 >= (w18 - r18);
        top_sq   = ry18 < r18;
        bot_sq   = ry18 >= (h18 - r18);
        cx_l     = r18 - rx18;
        cx_r     = rx18 - (w18 - r18 - 18'sd1);
        cy_t     = r18 - ry18;
        cy_b     = ry18 - (h18 - r18 - 18'sd1);
        n_corner = 1'b1;
        if (left_sq && top_sq) begin
            n_cx = cx_l[6:0];
            n_cy = cy_t[6:0];
        end else if (right_sq && top_sq) begin
            n_cx = cx_r[6:0];
            n_cy = cy_t[6:0];
        end else if (left_sq && bot_sq) begin
            n_cx = cx_l[6:0];
            n_cy = cy_b[6:0];
        end else if (right_sq && bot_sq) begin
            n_cx = cx_r[6:0];
            n_cy = cy_b[6:0];
        end else begin
            n_cx     = '0;
            n_cy     = '0;
            n_corner = 1'b0;
        end
    end

    logic               r_s1_valid;
    logic               r_s1_inside;
    logic               r_s1_corner;
    logic signed [15:0] r_s1_x;
    logic signed [15:0] r_s1_y;
    logic [14:0]        r_s1_ry;
    logic [6:0]         r_s1_cx;
    logic [6:0]         r_s1_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_s0_valid;
        end
        r_s1_inside <= n_inside;
        r_s1_corner <= n_corner;
        r_s1_x      <= r_s0_x;
        r_s1_y      <= r_s0_y;
        r_s1_ry     <= r_s0_ry[14:0];
        r_s1_cx     <= n_cx;
        r_s1_cy     <= n_cy;
    end

    // stage 2: squared distance and seeds for divide and square root
    t_work r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= r_s1_valid;
        end
        r_s2.in_rect <= r_s1_inside;
        r_s2.corner  <= r_s1_corner;
        r_s2.x       <= r_s1_x;
        r_s2.y       <= r_s1_y;
        r_s2.d2      <= D2_BITS'({7'b0, r_s1_cx} * {7'b0, r_s1_cx})
                      + D2_BITS'({7'b0, r_s1_cy} * {7'b0, r_s1_cy});
        r_s2.drem    <= {1'b0, r_s1_ry, 8'b0};
        r_s2.dq      <= '0;
        r_s2.srem    <= '0;
        r_s2.sq      <= '0;
    end

    // iterative stages: row weight quotient in Q1.8 and corner distance in Q.16
    t_work w_stage [0:SQRT_STEPS];

    assign w_stage[0] = r_s2;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_iter
        rrgs_iter_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_denom (denom),
            .i_prev  (w_stage[g]),
            .o_work  (w_stage[g+1])
        );
    end

    t_work w_last;
    assign w_last = w_stage[SQRT_STEPS];

    // tail stage 1: gradient blend and smoothstep band test
    logic signed [24:0] diff;
    logic signed [24:0] tt_full;
    logic [31:0]        n_color;
    logic [16:0]        ch_sum;
    logic [8:0]         tw;

    always_comb begin
        tw      = w_last.dq;
        n_color = '0;
        for (int c = 0; c < 4; c++) begin
            ch_sum = 17'(r_top_color[c*8 +: 8] * (9'd256 - tw))
                   + 17'(r_bot_color[c*8 +: 8] * tw) + 17'd128;
            n_color[c*8 +: 8] = ch_sum[15:8];
        end
        diff    = $signed({1'b0, w_last.sq}) - $signed({2'b0, rad, 16'b0});
        tt_full = 25'sd65536 - diff;
    end

    logic               r_t1_valid;
    logic               r_t1_inside;
    logic               r_t1_corner;
    logic signed [15:0] r_t1_x;
    logic signed [15:0] r_t1_y;
    logic               r_t1_zero;
    logic               r_t1_full;
    logic [15:0]        r_t1_tt;
    logic [31:0]        r_t1_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_valid <= 1'b0;
        end else begin
            r_t1_valid <= w_last.valid;
        end
        r_t1_inside <= w_last.in_rect;
        r_t1_corner <= w_last.corner;
        r_t1_x      <= w_last.x;
        r_t1_y      <= w_last.y;
        r_t1_zero   <= diff >= 25'sd65536;
        r_t1_full   <= diff <= -25'sd65536;
        r_t1_tt     <= tt_full[16:1];
        r_t1_color  <= n_color;
    end

    // tail stage 2: tt squared and the cubic factor
    logic [31:0] tt_sq;
    assign tt_sq = r_t1_tt * r_t1_tt;

    logic               r_t2_valid;
    logic               r_t2_inside;
    logic               r_t2_corner;
    logic signed [15:0] r_t2_x;
    logic signed [15:0] r_t2_y;
    logic               r_t2_zero;
    logic               r_t2_full;
    logic [15:0]        r_t2_tt2;
    logic [17:0]        r_t2_m;
    logic [31:0]        r_t2_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2_valid <= 1'b0;
        end else begin
            r_t2_valid <= r_t1_valid;
        end
        r_t2_inside <= r_t1_inside;
        r_t2_corner <= r_t1_corner;
        r_t2_x      <= r_t1_x;
        r_t2_y      <= r_t1_y;
        r_t2_zero   <= r_t1_zero;
        r_t2_full   <= r_t1_full;
        r_t2_tt2    <= tt_sq[31:16];
        r_t2_m      <= 18'd196608 - {1'b0, r_t1_tt, 1'b0};
        r_t2_color  <= r_t1_color;
    end

    // tail stage 3: smoothstep weight in Q0.16
    logic [33:0] s_prod;
    assign s_prod = r_t2_tt2 * r_t2_m;

    logic               r_t3_valid;
    logic               r_t3_inside;
    logic               r_t3_corner;
    logic signed [15:0] r_t3_x;
    logic signed [15:0] r_t3_y;
    logic               r_t3_zero;
    logic               r_t3_full;
    logic [17:0]        r_t3_s;
    logic [31:0]        r_t3_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t3_valid <= 1'b0;
        end else begin
            r_t3_valid <= r_t2_valid;
        end
        r_t3_inside <= r_t2_inside;
        r_t3_corner <= r_t2_corner;
        r_t3_x      <= r_t2_x;
        r_t3_y      <= r_t2_y;
        r_t3_zero   <= r_t2_zero;
        r_t3_full   <= r_t2_full;
        r_t3_s      <= s_prod[33:16];
        r_t3_color  <= r_t2_color;
    end

    // tail stage 4: corner alpha and the stored word
    logic [25:0] a_prod;
    logic [7:0]  alpha;
    logic        n_we;
    logic [31:0] n_pix;

    always_comb begin
        a_prod = r_t3_color[31:24] * r_t3_s;
        if (r_t3_zero) begin
            alpha = 8'd0;
        end else if (r_t3_full) begin
            alpha = r_t3_color[31:24];
        end else begin
            alpha = a_prod[23:16];
        end
        if (!r_t3_inside) begin
            n_we  = 1'b0;
            n_pix = '0;
        end else if (!r_t3_corner) begin
            n_we  = 1'b1;
            n_pix = r_t3_color;
        end else if (alpha != 8'd0) begin
            n_we  = 1'b1;
            n_pix = {alpha, r_t3_color[23:0]};
        end else begin
            n_we  = 1'b0;
            n_pix = '0;
        end
    end

    logic    r_out_valid;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_t3_valid;
        end
        r_out.write_enable <= n_we;
        r_out.out_x        <= r_t3_x;
        r_out.out_y        <= r_t3_y;
        r_out.pixel_color  <= n_pix;
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire
